@@ sv/vrt_pkg.sv @@
// shared types and constants of the voxel ray walker
package vrt_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DIR_W          = 16;
   localparam int LEN_W          = 32;
   localparam int SQ_W           = 32;
   localparam int DIST_W         = 33;
   localparam int ROOT_IN_W      = 2 * LEN_W;

   localparam logic [31:0]       REACH_RESET = 32'd524288;
   localparam logic [DIST_W-1:0] DIST_INF    = {DIST_W{1'b1}};

   // transaction kinds on the request channel
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_REPLY = 1'b1;

   // result kinds
   localparam logic [1:0] RK_LOOKUP = 2'd0;
   localparam logic [1:0] RK_HIT    = 2'd1;
   localparam logic [1:0] RK_MISS   = 2'd2;

   localparam logic [2:0] FACE_NONE = 3'd0;
   localparam logic [2:0] FACE_POS  = 3'd1;
   localparam logic [2:0] FACE_NEG  = 3'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_REPLY,
      OP_SQUARE,
      OP_SQRT,
      OP_DIV,
      OP_STORE,
      OP_TIE,
      OP_STEP
   } dp_op_type;

   typedef enum logic [1:0] {
      EM_NONE,
      EM_LOOKUP,
      EM_HIT,
      EM_MISS
   } emit_type;

   typedef struct packed {
      dp_op_type  op;
      emit_type   emit;
      logic       hit_origin;
      logic [1:0] axis;
      logic       sel_next;
      logic       take;
   } dp_cmd_type;

   typedef struct packed {
      logic req_valid;
      logic req_kind;
      logic reply_hit;
      logic len_zero;
      logic reach_zero;
      logic sqrt_busy;
      logic div_busy;
      logic dir_zero;
      logic tie_empty;
      logic beyond;
      logic overflow;
      logic out_free;
   } dp_status_type;

endpackage

@@ sv/vrt_if.sv @@
// request and result channel interfaces

interface vrt_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [31:0] cell_x;
   logic signed [31:0] cell_y;
   logic signed [31:0] cell_z;
   logic [15:0]        frac_x;
   logic [15:0]        frac_y;
   logic [15:0]        frac_z;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic               voxel_present;
   logic [15:0]        voxel_value;

   modport source (output valid, kind, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                   dir_x, dir_y, dir_z, voxel_present, voxel_value, input ready);
   modport sink (input valid, kind, cell_x, cell_y, cell_z, frac_x, frac_y, frac_z,
                 dir_x, dir_y, dir_z, voxel_present, voxel_value, output ready);
endinterface

interface vrt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic [15:0]        hit_value;
   logic [31:0]        hit_distance;
   logic [2:0]         hit_face;
   logic               adjacent_valid;

   modport source (output valid, result_kind, out_x, out_y, out_z, hit_value, hit_distance,
                   hit_face, adjacent_valid, input ready);
   modport sink (input valid, result_kind, out_x, out_y, out_z, hit_value, hit_distance,
                 hit_face, adjacent_valid, output ready);
endinterface

@@ sv/voxel_ray_traversal.sv @@
// Voxel ray walker top level. Between the acceptance of a start transaction and its first
// lookup request lie three squares, a bit-serial square root of 32 steps and up to six
// divisions through one shared restoring divider that retires one quotient bit per cycle;
// an axis with zero direction skips its two divisions. A reply transaction ends in a hit
// result or else goes through one minimum-compare step and one cell step. Results wait
// in an output register, so a new transaction is taken while the previous result is pending.
module voxel_ray_traversal
   import vrt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vrt_req_if.sink     req_ch,
   vrt_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   dp_cmd_type    cmd;
   dp_status_type st;

   vrt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   vrt_dp #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .st          (st)
   );
endmodule

@@ sv/vrt_div.sv @@
// restoring divider, one quotient bit per cycle
module vrt_div #(
   parameter int DW = 49,
   parameter int VW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] rem_ff;
   logic [VW-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic [VW:0]   shifted;
   logic [VW:0]   diff;
   logic          fits;

   // one shift and trial subtract
   always_comb begin
      shifted = {rem_ff, q_ff[DW-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == CW'(DW - 1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         cnt_ff <= '0;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[DW-2:0], fits};
         rem_ff <= fits ? diff[VW-1:0] : shifted[VW-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign busy     = busy_ff;
   assign quotient = q_ff;
endmodule

@@ sv/vrt_sqrt.sv @@
// bit-pair square root, one result bit per cycle
module vrt_sqrt #(
   parameter int IN_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [IN_W-1:0]   radicand,
   output logic              busy,
   output logic [IN_W/2-1:0] root
);
   logic [IN_W-1:0] n_ff;
   logic [IN_W-1:0] r_ff;
   logic [IN_W-1:0] b_ff;
   logic            busy_ff;
   logic [IN_W-1:0] trial;
   logic            fits;

   always_comb begin
      trial = r_ff + b_ff;
      fits  = n_ff >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && b_ff[0]) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff <= radicand;
         r_ff <= '0;
         b_ff <= {2'b01, {(IN_W-2){1'b0}}};
      end else if (busy_ff) begin
         if (fits) begin
            n_ff <= n_ff - trial;
            r_ff <= (r_ff >> 1) + b_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         b_ff <= b_ff >> 2;
      end
   end

   assign busy = busy_ff;
   assign root = r_ff[IN_W/2-1:0];
endmodule

@@ sv/vrt_dp.sv @@
// ray walker datapath: ray state, setup arithmetic and result register
module vrt_dp
   import vrt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   vrt_req_if.sink       req_ch,
   vrt_rsp_if.source     rsp_ch,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,
   input  dp_cmd_type    cmd,
   output dp_status_type st
);
   localparam int NUM_W = FRAC_BITS + 1;
   localparam int DIV_W = NUM_W + LEN_W;
   localparam int CX_W  = COORD_BITS + 1;

   logic [31:0]                  reach_ff;
   logic signed [COORD_BITS-1:0] cell_ff [3];
   logic signed [DIR_W-1:0]      dir_ff [3];
   logic [15:0]                  frac_ff [3];
   logic signed [1:0]            sign_ff [3];
   logic [DIST_W-1:0]            next_ff [3];
   logic [DIST_W-1:0]            delta_ff [3];
   logic [2:0]                   tie_ff;
   logic [31:0]                  dist_ff;
   logic [1:0]                   last_ff;
   logic [15:0]                  value_ff;
   logic                         hit_ff;
   logic [SQ_W-1:0]              sum_ff;

   logic                         rsp_valid_ff;
   logic [1:0]                   rsp_kind_ff;
   logic signed [31:0]           rsp_x_ff;
   logic signed [31:0]           rsp_y_ff;
   logic signed [31:0]           rsp_z_ff;
   logic [15:0]                  rsp_value_ff;
   logic [31:0]                  rsp_dist_ff;
   logic [2:0]                   rsp_face_ff;
   logic                         rsp_adj_ff;

   logic                         sqrt_busy;
   logic [LEN_W-1:0]             len;
   logic                         div_busy;
   logic [DIV_W-1:0]             quot;

   logic signed [DIR_W-1:0]      dsel;
   logic [DIR_W-1:0]             mag;
   logic signed [2*DIR_W-1:0]    square;
   logic [FRAC_BITS-1:0]         fr;
   logic [NUM_W-1:0]             fnum;
   logic [DIV_W-1:0]             num;
   logic [DIV_W-1:0]             dividend;
   logic [DIST_W-1:0]            m;
   logic [1:0]                   pa;
   logic [CX_W-1:0]              nc;
   logic [DIST_W:0]              nsum;
   logic [DIST_W-1:0]            nsat;
   logic [CX_W-1:0]              pc;
   logic [2:0]                   face;
   logic                         out_free;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         reach_ff <= REACH_RESET;
      end else if (csr_wr_en) begin
         reach_ff <= csr_wr_data;
      end
   end

   // setup arithmetic on the selected axis
   always_comb begin
      dsel     = dir_ff[cmd.axis];
      mag      = dsel[DIR_W-1] ? DIR_W'(-dsel) : DIR_W'(dsel);
      square   = dsel * dsel;
      fr       = FRAC_BITS'(frac_ff[cmd.axis]);
      fnum     = (dsel > 0) ? ({1'b1, {FRAC_BITS{1'b0}}} - {1'b0, fr}) : {1'b0, fr};
      num      = DIV_W'(fnum) * DIV_W'(len);
      dividend = cmd.sel_next ? num : DIV_W'(len);
   end

   // nearest crossing and the axis to step
   always_comb begin
      m = next_ff[0];
      if (next_ff[1] < m) m = next_ff[1];
      if (next_ff[2] < m) m = next_ff[2];
      pa   = tie_ff[0] ? 2'd0 : (tie_ff[1] ? 2'd1 : 2'd2);
      nc   = CX_W'(cell_ff[pa]) + {{(CX_W-2){sign_ff[pa][1]}}, sign_ff[pa]};
      nsum = {1'b0, next_ff[pa]} + {1'b0, delta_ff[pa]};
      nsat = (nsum >= {1'b0, DIST_INF}) ? DIST_INF : nsum[DIST_W-1:0];
   end

   // face entered on a hit after a step
   always_comb begin
      pc   = CX_W'(cell_ff[last_ff]) - {{(CX_W-2){sign_ff[last_ff][1]}}, sign_ff[last_ff]};
      face = {last_ff, 1'b0} + (sign_ff[last_ff][1] ? FACE_NEG : FACE_POS);
   end

   vrt_sqrt #(.IN_W(ROOT_IN_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_SQRT),
      .radicand ({sum_ff, {(ROOT_IN_W-SQ_W){1'b0}}}),
      .busy     (sqrt_busy),
      .root     (len)
   );

   vrt_div #(.DW(DIV_W), .VW(DIR_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV),
      .dividend (dividend),
      .divisor  (mag),
      .busy     (div_busy),
      .quotient (quot)
   );

   // ray state
   always_ff @(posedge clock) begin
      if (reset) begin
         tie_ff <= '0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               cell_ff[0] <= COORD_BITS'(req_ch.cell_x);
               cell_ff[1] <= COORD_BITS'(req_ch.cell_y);
               cell_ff[2] <= COORD_BITS'(req_ch.cell_z);
               dir_ff[0]  <= req_ch.dir_x;
               dir_ff[1]  <= req_ch.dir_y;
               dir_ff[2]  <= req_ch.dir_z;
               frac_ff[0] <= req_ch.frac_x;
               frac_ff[1] <= req_ch.frac_y;
               frac_ff[2] <= req_ch.frac_z;
               for (int a = 0; a < 3; a++) begin
                  sign_ff[a]  <= 2'sb00;
                  next_ff[a]  <= DIST_INF;
                  delta_ff[a] <= DIST_INF;
               end
               tie_ff  <= '0;
               dist_ff <= '0;
               last_ff <= '0;
               sum_ff  <= '0;
            end
            OP_REPLY: begin
               value_ff <= req_ch.voxel_value;
               hit_ff   <= req_ch.voxel_present && (req_ch.voxel_value != '0);
            end
            OP_SQUARE: begin
               sum_ff <= sum_ff + SQ_W'(unsigned'(square));
            end
            OP_DIV: begin
               sign_ff[cmd.axis] <= dsel[DIR_W-1] ? 2'sb11 : 2'sb01;
            end
            OP_STORE: begin
               if (cmd.sel_next) begin
                  next_ff[cmd.axis] <= quot[FRAC_BITS +: DIST_W];
               end else begin
                  delta_ff[cmd.axis] <= quot[DIST_W-1:0];
               end
            end
            OP_TIE: begin
               tie_ff  <= {next_ff[2] == m, next_ff[1] == m, next_ff[0] == m};
               dist_ff <= m[31:0];
            end
            OP_STEP: begin
               cell_ff[pa] <= nc[COORD_BITS-1:0];
               next_ff[pa] <= nsat;
               tie_ff[pa]  <= 1'b0;
               last_ff     <= pa;
            end
            OP_NONE, OP_SQRT: begin
            end
            default: begin
            end
         endcase
         if (cmd.emit == EM_HIT || cmd.emit == EM_MISS) begin
            tie_ff <= '0;
         end
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit != EM_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.emit)
         EM_LOOKUP, EM_HIT: begin
            rsp_kind_ff  <= (cmd.emit == EM_HIT) ? RK_HIT : RK_LOOKUP;
            rsp_x_ff     <= 32'(cell_ff[0]);
            rsp_y_ff     <= 32'(cell_ff[1]);
            rsp_z_ff     <= 32'(cell_ff[2]);
            rsp_value_ff <= (cmd.emit == EM_HIT) ? value_ff : '0;
            if (cmd.emit == EM_HIT && !cmd.hit_origin) begin
               rsp_dist_ff <= dist_ff;
               rsp_face_ff <= face;
               rsp_adj_ff  <= pc[COORD_BITS] == pc[COORD_BITS-1];
            end else begin
               rsp_dist_ff <= '0;
               rsp_face_ff <= FACE_NONE;
               rsp_adj_ff  <= 1'b0;
            end
         end
         EM_MISS: begin
            rsp_kind_ff  <= RK_MISS;
            rsp_x_ff     <= '0;
            rsp_y_ff     <= '0;
            rsp_z_ff     <= '0;
            rsp_value_ff <= '0;
            rsp_dist_ff  <= '0;
            rsp_face_ff  <= FACE_NONE;
            rsp_adj_ff   <= 1'b0;
         end
         EM_NONE: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = rsp_kind_ff;
   assign rsp_ch.out_x          = rsp_x_ff;
   assign rsp_ch.out_y          = rsp_y_ff;
   assign rsp_ch.out_z          = rsp_z_ff;
   assign rsp_ch.hit_value      = rsp_value_ff;
   assign rsp_ch.hit_distance   = rsp_dist_ff;
   assign rsp_ch.hit_face       = rsp_face_ff;
   assign rsp_ch.adjacent_valid = rsp_adj_ff;
   assign req_ch.ready          = cmd.take;

   // status toward the controller
   always_comb begin
      st.req_valid  = req_ch.valid;
      st.req_kind   = req_ch.kind;
      st.reply_hit  = hit_ff;
      st.len_zero   = sum_ff == '0;
      st.reach_zero = reach_ff == '0;
      st.sqrt_busy  = sqrt_busy;
      st.div_busy   = div_busy;
      st.dir_zero   = dsel == '0;
      st.tie_empty  = tie_ff == '0;
      st.beyond     = (m == DIST_INF) || (m > {1'b0, reach_ff});
      st.overflow   = nc[COORD_BITS] != nc[COORD_BITS-1];
      st.out_free   = out_free;
   end
endmodule

@@ sv/vrt_ctrl.sv @@
// ray walker controller: sequences setup, lookups and results
module vrt_ctrl
   import vrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  dp_status_type st,
   output dp_cmd_type    cmd
);
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_CHECK,
      ST_SQRT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_LOOKUP,
      ST_MISS,
      ST_REPLY,
      ST_HIT,
      ST_TIE,
      ST_STEP
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ORIGIN,
      PH_STEP
   } phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic [1:0] axis_ff;
   logic       sel_ff;

   // command decode
   always_comb begin
      cmd            = '0;
      cmd.op         = OP_NONE;
      cmd.emit       = EM_NONE;
      cmd.axis       = axis_ff;
      cmd.sel_next   = sel_ff;
      cmd.hit_origin = phase_ff == PH_ORIGIN;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take = 1'b1;
            if (st.req_valid) begin
               if (st.req_kind == KIND_START) begin
                  cmd.op = OP_LOAD;
               end else if (phase_ff != PH_IDLE) begin
                  cmd.op = OP_REPLY;
               end
            end
         end
         ST_SQUARE: cmd.op = OP_SQUARE;
         ST_CHECK: begin
            if (!(st.len_zero || st.reach_zero)) cmd.op = OP_SQRT;
         end
         ST_DIV_GO: begin
            if (!st.dir_zero) cmd.op = OP_DIV;
         end
         ST_DIV_WAIT: begin
            if (!st.div_busy) cmd.op = OP_STORE;
         end
         ST_LOOKUP: begin
            if (st.out_free) cmd.emit = EM_LOOKUP;
         end
         ST_MISS: begin
            if (st.out_free) cmd.emit = EM_MISS;
         end
         ST_HIT: begin
            if (st.out_free) cmd.emit = EM_HIT;
         end
         ST_TIE: begin
            if (st.tie_empty && !st.beyond) cmd.op = OP_TIE;
         end
         ST_STEP: begin
            if (!st.overflow) cmd.op = OP_STEP;
         end
         ST_SQRT, ST_REPLY: begin
         end
         default: begin
         end
      endcase
   end

   // state, phase and axis counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
         axis_ff  <= '0;
         sel_ff   <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               axis_ff <= '0;
               sel_ff  <= 1'b0;
               if (st.req_valid) begin
                  if (st.req_kind == KIND_START) begin
                     phase_ff <= PH_IDLE;
                     state_ff <= ST_SQUARE;
                  end else if (phase_ff != PH_IDLE) begin
                     state_ff <= ST_REPLY;
                  end
               end
            end
            ST_SQUARE: begin
               if (axis_ff == 2'd2) begin
                  axis_ff  <= '0;
                  state_ff <= ST_CHECK;
               end else begin
                  axis_ff <= axis_ff + 1'b1;
               end
            end
            ST_CHECK: begin
               state_ff <= (st.len_zero || st.reach_zero) ? ST_MISS : ST_SQRT;
            end
            ST_SQRT: begin
               if (!st.sqrt_busy) state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO: begin
               if (!st.dir_zero) begin
                  state_ff <= ST_DIV_WAIT;
               end else if (axis_ff == 2'd2) begin
                  phase_ff <= PH_ORIGIN;
                  state_ff <= ST_LOOKUP;
               end else begin
                  axis_ff <= axis_ff + 1'b1;
               end
            end
            ST_DIV_WAIT: begin
               if (!st.div_busy) begin
                  if (!sel_ff) begin
                     sel_ff   <= 1'b1;
                     state_ff <= ST_DIV_GO;
                  end else if (axis_ff == 2'd2) begin
                     sel_ff   <= 1'b0;
                     phase_ff <= PH_ORIGIN;
                     state_ff <= ST_LOOKUP;
                  end else begin
                     sel_ff   <= 1'b0;
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= ST_DIV_GO;
                  end
               end
            end
            ST_LOOKUP: begin
               if (st.out_free) state_ff <= ST_IDLE;
            end
            ST_MISS, ST_HIT: begin
               if (st.out_free) begin
                  phase_ff <= PH_IDLE;
                  state_ff <= ST_IDLE;
               end
            end
            ST_REPLY: begin
               state_ff <= st.reply_hit ? ST_HIT : ST_TIE;
            end
            ST_TIE: begin
               state_ff <= (st.tie_empty && st.beyond) ? ST_MISS : ST_STEP;
            end
            ST_STEP: begin
               if (st.overflow) begin
                  state_ff <= ST_MISS;
               end else begin
                  phase_ff <= PH_STEP;
                  state_ff <= ST_LOOKUP;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
